### sv/dbc_pkg.sv
// ----------------------------------------------------------------------------
// dbc_pkg
// Shared types, constants and display helpers for the directional beam counter.
// ----------------------------------------------------------------------------
package dbc_pkg;

    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned COUNT_W     = 7;
    localparam int unsigned S_TDATA_W   = 8;
    localparam int unsigned M_TDATA_W   = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SETTLE   = 8'd1;

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [CFG_DATA_W-1:0] SETTLE_RESET   = 16'd100;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd99;

    localparam logic [2:0] LEDS_ZERO    = 3'd2;
    localparam logic [2:0] LEDS_NONZERO = 3'd5;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] debounce_ticks;
        logic [CFG_DATA_W-1:0] settle_ticks;
    } dbc_cfg_t;

    // inverted (common anode) segment pattern of one decimal digit
    function automatic logic [7:0] dbc_segments(input logic [3:0] digit);
        logic [7:0] seg;
        unique case (digit)
            4'd0:    seg = 8'h3F;
            4'd1:    seg = 8'h06;
            4'd2:    seg = 8'h5B;
            4'd3:    seg = 8'h4F;
            4'd4:    seg = 8'h66;
            4'd5:    seg = 8'h6D;
            4'd6:    seg = 8'h7D;
            4'd7:    seg = 8'h07;
            4'd8:    seg = 8'h7F;
            4'd9:    seg = 8'h6F;
            default: seg = 8'h00;
        endcase
        return ~seg;
    endfunction

    // count / 10 for count <= 99 by reciprocal multiply
    function automatic logic [3:0] dbc_tens(input logic [COUNT_W-1:0] cnt);
        logic [14:0] prod;
        prod = 15'(cnt) * 15'd205;
        return prod[14:11];
    endfunction

    function automatic logic [3:0] dbc_units(input logic [COUNT_W-1:0] cnt,
                                             input logic [3:0] tens);
        logic [COUNT_W-1:0] t10;
        logic [COUNT_W-1:0] diff;
        t10  = COUNT_W'({tens, 3'b000}) + COUNT_W'({tens, 1'b0});
        diff = cnt - t10;
        return diff[3:0];
    endfunction

endpackage

### sv/dbc_ctrl.sv
// ----------------------------------------------------------------------------
// dbc_ctrl
// Sensor and button sequencer with the saturating visitor count.
// ----------------------------------------------------------------------------
module dbc_ctrl import dbc_pkg::*; #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               item_acc,
    input  logic               sensor_a,
    input  logic               sensor_b,
    input  logic               clear_button_n,
    input  logic               up_button_n,
    input  logic               down_button_n,
    input  dbc_cfg_t           cfg,
    output logic [COUNT_W-1:0] count_next
);

    localparam logic [2:0] PH_IDLE         = 3'd0;
    localparam logic [2:0] PH_SENSOR_CHECK = 3'd1;
    localparam logic [2:0] PH_SETTLE       = 3'd2;
    localparam logic [2:0] PH_BOTH_CHECK   = 3'd3;
    localparam logic [2:0] PH_HOLD         = 3'd4;
    localparam logic [2:0] PH_BUTTON_CHECK = 3'd5;

    localparam logic [2:0] ACT_NONE  = 3'd0;
    localparam logic [2:0] ACT_A     = 3'd1;
    localparam logic [2:0] ACT_B     = 3'd2;
    localparam logic [2:0] ACT_CLEAR = 3'd3;
    localparam logic [2:0] ACT_UP    = 3'd4;
    localparam logic [2:0] ACT_DOWN  = 3'd5;

    localparam logic [32:0] TIMER_CAP = (33'd1 << TIMER_BITS) - 33'd1;

    logic [2:0]            phase_reg, phase_next;
    logic [2:0]            act_reg, act_next;
    logic [TIMER_BITS-1:0] timer_reg, timer_next;
    logic [COUNT_W-1:0]    count_reg;

    logic both;
    logic clr, up, dn;
    logic due;
    logic own;
    logic held;

    function automatic logic [TIMER_BITS-1:0] timer_load(input logic [CFG_DATA_W-1:0] ticks);
        logic [32:0] wide;
        wide = 33'(ticks);
        if (wide > TIMER_CAP) begin
            return TIMER_CAP[TIMER_BITS-1:0];
        end
        return wide[TIMER_BITS-1:0];
    endfunction

    function automatic logic [COUNT_W-1:0] apply_action(input logic [2:0] act,
                                                        input logic [COUNT_W-1:0] cnt);
        logic [COUNT_W-1:0] res;
        res = cnt;
        if (act == ACT_A || act == ACT_UP) begin
            if (cnt < COUNT_MAX) res = cnt + COUNT_W'(1);
        end else if (act == ACT_B || act == ACT_DOWN) begin
            if (cnt != '0) res = cnt - COUNT_W'(1);
        end else if (act == ACT_CLEAR) begin
            res = '0;
        end
        return res;
    endfunction

    assign both = sensor_a & sensor_b;
    assign clr  = ~clear_button_n;
    assign up   = ~up_button_n;
    assign dn   = ~down_button_n;
    assign own  = (act_reg == ACT_A) ? sensor_a : sensor_b;

    always_comb begin
        priority if (act_reg == ACT_CLEAR) begin
            held = clr;
        end else if (act_reg == ACT_UP) begin
            held = up;
        end else if (act_reg == ACT_DOWN) begin
            held = dn;
        end else begin
            held = 1'b0;
        end
    end

    always_comb begin
        phase_next = phase_reg;
        act_next   = act_reg;
        timer_next = timer_reg;
        count_next = count_reg;
        due        = 1'b0;

        if (phase_reg == PH_SENSOR_CHECK || phase_reg == PH_SETTLE ||
            phase_reg == PH_BOTH_CHECK || phase_reg == PH_BUTTON_CHECK) begin
            if (timer_reg > TIMER_BITS'(1)) begin
                timer_next = timer_reg - TIMER_BITS'(1);
            end else begin
                due = 1'b1;
            end
        end

        unique case (phase_reg)
            PH_IDLE: begin
                priority if (sensor_a) begin
                    act_next   = ACT_A;
                    phase_next = PH_SENSOR_CHECK;
                    timer_next = timer_load(cfg.debounce_ticks);
                end else if (sensor_b) begin
                    act_next   = ACT_B;
                    phase_next = PH_SENSOR_CHECK;
                    timer_next = timer_load(cfg.debounce_ticks);
                end else if (clr) begin
                    act_next   = ACT_CLEAR;
                    phase_next = PH_BUTTON_CHECK;
                    timer_next = timer_load(cfg.debounce_ticks);
                end else if (up) begin
                    act_next   = ACT_UP;
                    phase_next = PH_BUTTON_CHECK;
                    timer_next = timer_load(cfg.debounce_ticks);
                end else if (dn) begin
                    act_next   = ACT_DOWN;
                    phase_next = PH_BUTTON_CHECK;
                    timer_next = timer_load(cfg.debounce_ticks);
                end else begin
                    phase_next = PH_IDLE;
                end
            end
            PH_SENSOR_CHECK: begin
                if (due) begin
                    if (own) begin
                        phase_next = PH_SETTLE;
                        timer_next = timer_load(cfg.settle_ticks);
                    end else begin
                        phase_next = PH_IDLE;
                        act_next   = ACT_NONE;
                        timer_next = '0;
                    end
                end
            end
            PH_SETTLE: begin
                if (due) begin
                    if (both) begin
                        phase_next = PH_BOTH_CHECK;
                        timer_next = timer_load(cfg.debounce_ticks);
                    end else begin
                        phase_next = PH_IDLE;
                        act_next   = ACT_NONE;
                        timer_next = '0;
                    end
                end
            end
            PH_BOTH_CHECK: begin
                if (due) begin
                    if (both) begin
                        count_next = apply_action(act_reg, count_reg);
                        phase_next = PH_HOLD;
                        timer_next = '0;
                    end else begin
                        phase_next = PH_IDLE;
                        act_next   = ACT_NONE;
                        timer_next = '0;
                    end
                end
            end
            PH_HOLD: begin
                if (!both) begin
                    phase_next = PH_IDLE;
                    act_next   = ACT_NONE;
                    timer_next = '0;
                end
            end
            PH_BUTTON_CHECK: begin
                if (due) begin
                    if (held) begin
                        count_next = apply_action(act_reg, count_reg);
                    end
                    phase_next = PH_IDLE;
                    act_next   = ACT_NONE;
                    timer_next = '0;
                end
            end
            default: begin
                phase_next = PH_IDLE;
                act_next   = ACT_NONE;
                timer_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            act_reg   <= ACT_NONE;
            timer_reg <= '0;
            count_reg <= '0;
        end else if (item_acc) begin
            phase_reg <= phase_next;
            act_reg   <= act_next;
            timer_reg <= timer_next;
            count_reg <= count_next;
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX)
        else $error("count above limit");

    a_idle_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> (act_reg == ACT_NONE && timer_reg == '0))
        else $error("idle with pending action or timer");

    a_hold_sensor: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_HOLD |-> (act_reg == ACT_A || act_reg == ACT_B))
        else $error("hold without sensor action");

    a_hold_release: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_acc && phase_reg == PH_HOLD && !both) |=> phase_reg == PH_IDLE)
        else $error("hold not released");

    a_count_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (!item_acc) |=> $stable(count_reg))
        else $error("count moved without item");

endmodule

### sv/directional_beam_counter_top.sv
// ----------------------------------------------------------------------------
// directional_beam_counter_top
// Two-way beam visitor counter with two-digit seven-segment output.
// ----------------------------------------------------------------------------
// Input stream s_*: one pin sample per item, one tick per item. Each item
// yields exactly one result item on m_* carrying both inverted digit
// patterns, the status LED pattern and the count after that tick.
// The result is registered in the output buffer described below.
// Throughput: one item per cycle while s_tready is high; the sequencer step
// is a single registered update of phase, action, delay timer and count.
// A two-entry output buffer (result register plus skid register) lets the
// block take a new item while a result waits; s_tready drops only when both
// entries hold untaken results.
// Configuration: cfg_index 0 is debounce_ticks, 1 is settle_ticks; other
// indexes are ignored. cfg_ready is always high; write only while idle.
// Reset (aresetn low, synchronous): sequencer idle, count 0, registers back
// to 20 and 100, output buffer empty.
// ----------------------------------------------------------------------------
module directional_beam_counter_top import dbc_pkg::*; #(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [0] sensor_a, [1] sensor_b, [2] clear_button_n, [3] up_button_n,
    // [4] down_button_n, [7:5] zero
    input  logic [S_TDATA_W-1:0]   s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [7:0] tens_segments, [15:8] units_segments, [18:16] status_leds,
    // [25:19] count_value, [31:26] zero
    output logic [M_TDATA_W-1:0]   m_tdata,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    dbc_cfg_t cfg_reg;

    logic                 item_acc;
    logic                 res_take;
    logic [COUNT_W-1:0]   count_next;
    logic [3:0]           tens;
    logic [3:0]           units;
    logic [M_TDATA_W-1:0] result;

    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 skid_valid_reg;
    logic [M_TDATA_W-1:0] skid_data_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RESET;
            cfg_reg.settle_ticks   <= SETTLE_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == REG_DEBOUNCE) begin
                cfg_reg.debounce_ticks <= cfg_data;
            end else if (cfg_index == REG_SETTLE) begin
                cfg_reg.settle_ticks <= cfg_data;
            end
        end
    end

    assign s_tready = ~skid_valid_reg;
    assign item_acc = s_tvalid & s_tready;
    assign res_take = out_valid_reg & m_tready;

    dbc_ctrl #(
        .TIMER_BITS (TIMER_BITS)
    ) u_ctrl (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .item_acc       (item_acc),
        .sensor_a       (s_tdata[0]),
        .sensor_b       (s_tdata[1]),
        .clear_button_n (s_tdata[2]),
        .up_button_n    (s_tdata[3]),
        .down_button_n  (s_tdata[4]),
        .cfg            (cfg_reg),
        .count_next     (count_next)
    );

    assign tens  = dbc_tens(count_next);
    assign units = dbc_units(count_next, tens);

    assign result = {6'b000000,
                     count_next,
                     (count_next == '0) ? LEDS_ZERO : LEDS_NONZERO,
                     dbc_segments(units),
                     dbc_segments(tens)};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (res_take) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (item_acc) begin
            if (out_valid_reg && !res_take) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end else if (res_take) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (res_take) begin
                out_data_reg <= skid_data_reg;
            end
        end else if (item_acc) begin
            if (out_valid_reg && !res_take) begin
                skid_data_reg <= result;
            end else begin
                out_data_reg <= result;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    a_skid_order: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry without result entry");

endmodule
